// ===== design/circular_deque_defines.svh =====
// Assertion macros shared by the circular deque checker.
// Depends on nothing; the including scope must provide clk_i and rst_ni.
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define DQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define DQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/dq_pkg.sv =====
// Shared types, constants and codes for the circular deque.
// Depends on nothing; the controller, datapath, top level and checker import it.
package dq_pkg;

  // Built ring depth and derived widths.
  localparam int DEPTH = 16;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CAP_W = 5;
  localparam int CMP_W = (CAP_W > CNT_W) ? CAP_W : CNT_W;
  localparam int WORD_W = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Operation codes of an input beat.
  typedef enum logic [2:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_REAR  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_REAR   = 3'd3,
    KIND_QUERY      = 3'd4
  } kind_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic [2:0]               kind;
    logic signed [WORD_W-1:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic                     ok;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
    logic [4:0]               item_count;
    logic                     is_empty;
    logic                     is_full;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic exec;
    logic load;
    logic cfg_wr;
  } dq_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_busy;
  } dq_status_t;

endpackage

// ===== design/dq_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
// Depends on nothing.
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]                           rdata_a_o,
  output logic [WIDTH-1:0]                           rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== design/dq_ctrl.sv =====
// Controller state machine for the circular deque.
// Depends on dq_pkg for the state type and the command and status structs.
module dq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               cfg_valid_i,
  input  logic               out_ready_i,
  input  dq_pkg::dq_status_t status_i,
  output logic               in_ready_o,
  output logic               cfg_ready_o,
  output dq_pkg::dq_cmd_t    cmd_o
);
  import dq_pkg::*;

  state_e state_q, state_d;
  logic   can_load;

  // The output register can take a result when empty or being drained.
  assign can_load = !status_i.out_busy || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !cfg_valid_i) state_d = ST_READ;
      end
      ST_READ: state_d = ST_LOAD;
      ST_LOAD: begin
        if (can_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs. A configuration beat wins over an input beat in the same cycle.
  always_comb begin
    in_ready_o  = 1'b0;
    cfg_ready_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        cfg_ready_o  = 1'b1;
        in_ready_o   = !cfg_valid_i;
        cmd_o.exec   = in_valid_i && !cfg_valid_i;
        cmd_o.cfg_wr = cfg_valid_i;
      end
      ST_READ: begin
      end
      ST_LOAD: cmd_o.load = can_load;
      default: begin
      end
    endcase
  end

endmodule

// ===== design/dq_datapath.sv =====
// Datapath of the circular deque: pointers, count, capacity, slot RAM, result.
// Depends on dq_pkg and dq_ram.
module dq_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dq_pkg::dq_cmd_t        cmd_i,
  input  dq_pkg::in_item_t       in_data_i,
  input  logic [dq_pkg::CAP_W-1:0] cfg_data_i,
  input  logic                   out_ready_i,
  output dq_pkg::dq_status_t     status_o,
  output logic                   out_valid_o,
  output dq_pkg::out_item_t      out_data_o
);
  import dq_pkg::*;

  logic [PTR_W-1:0] front_q, front_d, rear_q, rear_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CAP_W-1:0] cap_q;
  logic             ok_q, ok_d;
  logic             out_valid_q;
  out_item_t        out_q;

  logic [CMP_W-1:0] cap_ext;
  logic [CNT_W-1:0] eff_cap;
  logic [PTR_W-1:0] front_inc, front_dec, rear_inc, rear_dec;
  logic             we;
  logic [PTR_W-1:0] waddr;
  logic [WORD_W-1:0] rd_front, rd_rear;

  // Effective capacity: zero reads as one, above the depth as the depth.
  assign cap_ext = CMP_W'(cap_q);
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CNT_W'(1);
    end else if (cap_ext > CMP_W'(DEPTH)) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = CNT_W'(cap_ext);
    end
  end

  // Pointer steps that wrap at the effective capacity.
  always_comb begin
    front_inc = ((CNT_W'(front_q) + CNT_W'(1)) >= eff_cap) ? '0 : front_q + PTR_W'(1);
    rear_inc  = ((CNT_W'(rear_q) + CNT_W'(1)) >= eff_cap) ? '0 : rear_q + PTR_W'(1);
    front_dec = (front_q == '0 || CNT_W'(front_q) >= eff_cap) ?
                PTR_W'(eff_cap - CNT_W'(1)) : front_q - PTR_W'(1);
    rear_dec  = (rear_q == '0 || CNT_W'(rear_q) >= eff_cap) ?
                PTR_W'(eff_cap - CNT_W'(1)) : rear_q - PTR_W'(1);
  end

  // Operation decode. A failed or unknown operation keeps the state.
  always_comb begin
    front_d = front_q;
    rear_d  = rear_q;
    count_d = count_q;
    ok_d    = 1'b0;
    we      = 1'b0;
    waddr   = '0;
    case (in_data_i.kind)
      KIND_PUSH_FRONT, KIND_PUSH_REAR: begin
        if (count_q < eff_cap) begin
          ok_d    = 1'b1;
          we      = cmd_i.exec;
          count_d = count_q + CNT_W'(1);
          if (count_q == '0) begin
            front_d = '0;
            rear_d  = '0;
          end else if (in_data_i.kind == KIND_PUSH_FRONT) begin
            front_d = front_dec;
            waddr   = front_dec;
          end else begin
            rear_d = rear_inc;
            waddr  = rear_inc;
          end
        end
      end
      KIND_POP_FRONT, KIND_POP_REAR: begin
        if (count_q != '0) begin
          ok_d    = 1'b1;
          count_d = count_q - CNT_W'(1);
          if (in_data_i.kind == KIND_POP_FRONT) begin
            front_d = front_inc;
          end else begin
            rear_d = rear_dec;
          end
          if (count_q == CNT_W'(1)) begin
            front_d = '0;
            rear_d  = '0;
          end
        end
      end
      KIND_QUERY: ok_d = 1'b1;
      default: ok_d = 1'b0;
    endcase
  end

  // Queue state registers; a capacity write empties the queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      rear_q  <= '0;
      count_q <= '0;
      cap_q   <= CAP_RESET;
      ok_q    <= 1'b0;
    end else if (cmd_i.cfg_wr) begin
      front_q <= '0;
      rear_q  <= '0;
      count_q <= '0;
      cap_q   <= cfg_data_i;
    end else if (cmd_i.exec) begin
      front_q <= front_d;
      rear_q  <= rear_d;
      count_q <= count_d;
      ok_q    <= ok_d;
    end
  end

  // Slot storage, read at the current front and rear pointers.
  dq_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (in_data_i.data_value),
    .raddr_a_i(front_q),
    .raddr_b_i(rear_q),
    .rdata_a_o(rd_front),
    .rdata_b_o(rd_rear)
  );

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register; an empty queue reports minus one at both ends.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q.ok          <= ok_q;
      out_q.front_value <= (count_q == '0) ? '1 : rd_front;
      out_q.rear_value  <= (count_q == '0) ? '1 : rd_rear;
      out_q.item_count  <= 5'(count_q);
      out_q.is_empty    <= (count_q == '0);
      out_q.is_full     <= (count_q == eff_cap);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;
  assign status_o.out_busy = out_valid_q;

endmodule

// ===== design/circular_deque.sv =====
// Top level of the circular deque: joins the controller and the datapath.
// Depends on dq_pkg, dq_ctrl and dq_datapath.
//
//   Channel   Direction  Handshake              Beat
//   in        input      in_valid_i/in_ready_o   in_item_t (kind, data_value)
//   out       output     out_valid_o/out_ready_i out_item_t (ok, ends, count, flags)
//   cfg       input      cfg_valid_i/cfg_ready_o capacity, 5 bits
//
// From acceptance to its result in the output register an item passes these
// steps: update of pointers and slot write, registered RAM read, load.
// One item is in work at a time; the input is ready again once its result
// is loaded, so a held result does not stop the next item from entering.
// The load waits while the previous result has not been taken.
// Reset empties the queue and sets the capacity to 16; no clearing pass.
module circular_deque (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  dq_pkg::in_item_t        in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output dq_pkg::out_item_t       out_data_o,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [dq_pkg::CAP_W-1:0] cfg_data_i
);
  import dq_pkg::*;

  dq_cmd_t    cmd;
  dq_status_t status;

  dq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cfg_valid_i(cfg_valid_i),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .in_ready_o (in_ready_o),
    .cfg_ready_o(cfg_ready_o),
    .cmd_o      (cmd)
  );

  dq_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .cfg_data_i (cfg_data_i),
    .out_ready_i(out_ready_i),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o)
  );

endmodule

// ===== design/dq_checker.sv =====
// Port-level checker for the circular deque, bound to the top level.
// Depends on dq_pkg and circular_deque_defines.svh.
`include "circular_deque_defines.svh"

module dq_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input dq_pkg::out_item_t        out_data_o,
  input logic                     cfg_ready_o
);
  import dq_pkg::*;

  logic out_stall;
  logic in_fire;
  logic out_empty;
  logic empty_flag_ok;
  logic ends_minus_one;

  // Short names for the conditions that the assertions look at.
  assign out_stall      = out_valid_o && !out_ready_i;
  assign in_fire        = in_valid_i && in_ready_o;
  assign out_empty      = out_valid_o && out_data_o.is_empty;
  assign empty_flag_ok  = out_data_o.is_empty == (out_data_o.item_count == 5'd0);
  assign ends_minus_one = (out_data_o.front_value == -32'sd1) &&
                          (out_data_o.rear_value == -32'sd1);

  // A result beat stays offered until it is taken.
  `DQ_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(out_data_o), "result not held")

  // The empty flag agrees with the count.
  `DQ_ASSERT_NOW(a_empty_count, out_valid_o, empty_flag_ok, "empty flag disagrees with count")

  // An empty queue reports minus one at both ends.
  `DQ_ASSERT_NOW(a_empty_ends, out_empty, ends_minus_one, "empty queue ends are not minus one")

  // One item in work at a time: no new beat right after one is taken.
  `DQ_ASSERT_NEXT(a_one_item, in_fire, !in_ready_o && !cfg_ready_o, "new beat taken while busy")

endmodule

bind circular_deque dq_checker u_dq_checker (.*);
